### sv/assert_macros.svh
// Assertion helpers for the display controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SSBD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SSBD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### sv/ssbd_pkg.sv
package ssbd_pkg;

    localparam int DIGITS = 4;                              // 1 .. 8
    localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int POS_W  = 4;
    localparam int REG_W  = 4;
    localparam int SEG_W  = 8;
    localparam int PER_W  = 16;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
    localparam logic [SEG_W-1:0] SEG_LSB   = 8'h01;
    localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

    typedef enum logic [2:0] {
        ACT_PUT_CHAR = 3'd0,
        ACT_PUT_SEGS = 3'd1,
        ACT_SET_SEG  = 3'd2,
        ACT_SET_BLNK = 3'd3,
        ACT_TICK     = 3'd4,
        ACT_CLEAR    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic load_item;   // capture input word, clear digit index
        logic exec_host;   // apply host action, load its result
        logic tick_step;   // advance one digit's blink timer, load its result
    } ssbd_cmd_t;

    typedef struct packed {
        logic in_is_tick;  // word on the input port is a refresh tick
        logic out_free;    // result register can take a word this cycle
        logic idx_last;    // digit index at the final digit
    } ssbd_sts_t;

    // ASCII to segments, A=6 .. G=0, DP left clear
    function automatic logic [SEG_W-1:0] font_lookup(input logic [7:0] c);
        logic [SEG_W-1:0] f;
        case (c)
            8'h30: f = 8'h7E;
            8'h31: f = 8'h30;
            8'h32: f = 8'h6D;
            8'h33: f = 8'h79;
            8'h34: f = 8'h33;
            8'h35: f = 8'h5B;
            8'h36: f = 8'h5F;
            8'h37: f = 8'h70;
            8'h38: f = 8'h7F;
            8'h39: f = 8'h7B;
            8'h41, 8'h61: f = 8'h77;
            8'h42, 8'h62: f = 8'h1F;
            8'h43:        f = 8'h4E;
            8'h63:        f = 8'h0D;
            8'h44, 8'h64: f = 8'h3D;
            8'h45, 8'h65: f = 8'h4F;
            8'h46, 8'h66: f = 8'h47;
            8'h47, 8'h67: f = 8'h5E;
            8'h2D: f = 8'h01;       // minus
            8'h5F: f = 8'h08;       // underscore
            8'h5B: f = 8'h4E;       // open bracket
            8'h5D: f = 8'h78;       // close bracket
            8'h7B: f = 8'h31;       // open brace
            8'h7D: f = 8'h07;       // close brace
            8'h48: f = 8'h37;
            8'h68: f = 8'h17;
            8'h4C, 8'h6C: f = 8'h0E;
            8'h4F, 8'h6F: f = 8'h1D;
            8'h50, 8'h70: f = 8'h67;
            default: f = SEG_BLANK;
        endcase
        return f;
    endfunction

    // 180-degree turn: A<->D, B<->E, C<->F, G and DP stay
    function automatic logic [SEG_W-1:0] seg_rotate(input logic [SEG_W-1:0] v,
                                                    input logic en);
        logic [SEG_W-1:0] r;
        r = {v[7], v[3], v[2], v[1], v[6], v[5], v[4], v[0]};
        return en ? r : v;
    endfunction

endpackage

### sv/seven_segment_blink_display_controller.sv
// Seven-segment display controller with per-digit blinking. It holds one segment
// byte (DP=7, A=6 .. G=0), a blink period, a blink counter and a blink phase for
// each of DIGITS digits (4 by default). Host words write a character through the
// built-in font, write or merge raw segments, set or clear one segment, set a
// blink period, or set every digit to the given bits with blinking off; each gives
// one result word carrying only a status (1 = position out of range, nothing
// changed) with last set. A refresh tick steps every digit's blink timer and gives
// DIGITS result words, digit 0 first, each a display-register write (register =
// digit + 1, data blanked in the off phase), last on the final one. mirror_enable
// (cfg_wr_en/cfg_wr_data) turns later writes by 180 degrees: position p goes to
// digit DIGITS-1-p and A<->D, B<->E, C<->F; write it only while the block is idle.
// Sequence: a host word is captured, then executed; a tick is captured, then the
// per-digit state is visited by one shared read index, one digit per cycle while
// the result register has room. A result register held full by m_ready low stalls
// the block. A new word is taken once the previous one has put its last result
// into the output register, even if that result has not yet been taken.
`include "assert_macros.svh"

module seven_segment_blink_display_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    // input word
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_position,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_segment_bits,
    input  logic [2:0]  s_segment_index,
    input  logic        s_lit,
    input  logic        s_with_dot,
    input  logic        s_merge_only,
    input  logic [15:0] s_blink_period,
    // result word
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_digit_register,
    output logic [7:0]  m_digit_data,
    output logic        m_status,
    output logic        m_last
);
    import ssbd_pkg::*;

    ssbd_cmd_t cmd;     // controller -> datapath
    ssbd_sts_t sts;     // datapath -> controller

    // Sequencer: idle / execute host word / walk the digits on a tick.
    ssbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Digit state, font, mirroring, blink timers and result register.
    ssbd_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_action         (s_action),
        .s_position       (s_position),
        .s_char_code      (s_char_code),
        .s_segment_bits   (s_segment_bits),
        .s_segment_index  (s_segment_index),
        .s_lit            (s_lit),
        .s_with_dot       (s_with_dot),
        .s_merge_only     (s_merge_only),
        .s_blink_period   (s_blink_period),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digit_register (m_digit_register),
        .m_digit_data     (m_digit_data),
        .m_status         (m_status),
        .m_last           (m_last),
        .cmd              (cmd),
        .sts              (sts)
    );

    // A result is only loaded when the output register has room.
    `SSBD_ASSERT(a_load_room, aclk, aresetn, (cmd.exec_host || cmd.tick_step) |-> sts.out_free, "result loaded into a full output register")
    // Host execution and tick stepping are exclusive.
    `SSBD_ASSERT_NEVER(a_cmd_excl, aclk, aresetn, cmd.exec_host && cmd.tick_step, "host execute and tick step together")
    // In the cycle after a word is taken the block is busy.
    `SSBD_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "input taken again right after acceptance")
    // Loading the final digit of a tick returns the block to idle.
    `SSBD_ASSERT(a_tick_done_idle, aclk, aresetn, (cmd.tick_step && sts.idx_last) |=> s_ready, "block not idle after final tick digit")

endmodule

### sv/ssbd_ctrl.sv
module ssbd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssbd_pkg::ssbd_sts_t sts,
    output ssbd_pkg::ssbd_cmd_t cmd
);
    import ssbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = sts.in_is_tick ? ST_TICK : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.out_free) begin
                    cmd.exec_host = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (sts.out_free) begin
                    cmd.tick_step = 1'b1;
                    if (sts.idx_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/ssbd_datapath.sv
module ssbd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [2:0]          s_action,
    input  logic [3:0]          s_position,
    input  logic [7:0]          s_char_code,
    input  logic [7:0]          s_segment_bits,
    input  logic [2:0]          s_segment_index,
    input  logic                s_lit,
    input  logic                s_with_dot,
    input  logic                s_merge_only,
    input  logic [15:0]         s_blink_period,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_digit_register,
    output logic [7:0]          m_digit_data,
    output logic                m_status,
    output logic                m_last,
    input  ssbd_pkg::ssbd_cmd_t cmd,
    output ssbd_pkg::ssbd_sts_t sts
);
    import ssbd_pkg::*;

    // configuration and per-digit state
    logic             mirror_reg;
    logic [SEG_W-1:0] seg_mem_reg [DIGITS];
    logic [PER_W-1:0] per_mem_reg [DIGITS];
    logic [PER_W-1:0] cnt_mem_reg [DIGITS];
    logic             ph_mem_reg  [DIGITS];
    logic [DIG_W-1:0] idx_reg;

    // captured input word
    logic [2:0]       act_reg;
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       chr_reg;
    logic [SEG_W-1:0] bits_reg;
    logic [2:0]       segi_reg;
    logic             lit_reg;
    logic             dot_reg;
    logic             merge_reg;
    logic [PER_W-1:0] period_reg;

    // result register
    logic             out_valid_reg;
    logic [REG_W-1:0] out_dreg_reg;
    logic [SEG_W-1:0] out_data_reg;
    logic             out_status_reg;
    logic             out_last_reg;

    logic             bad;
    logic [DIG_W-1:0] dest;
    logic [DIG_W-1:0] rd_idx;
    logic [SEG_W-1:0] seg_rd;
    logic [SEG_W-1:0] char_pat;
    logic [SEG_W-1:0] rot_bits;
    logic [SEG_W-1:0] rot_mask;
    logic             seg_we;
    logic [SEG_W-1:0] seg_next;
    logic             per_we;
    logic             clr;
    logic             host_status;
    logic [PER_W-1:0] cnt_next;
    logic             ph_next;
    logic             out_load;
    logic [REG_W-1:0] out_dreg_next;
    logic [SEG_W-1:0] out_data_next;
    logic             out_status_next;
    logic             out_last_next;

    assign bad    = (pos_reg >= POS_W'(DIGITS));
    assign dest   = mirror_reg ? DIG_W'(POS_W'(DIGITS - 1) - pos_reg) : DIG_W'(pos_reg);
    assign rd_idx = cmd.tick_step ? idx_reg : dest;
    assign seg_rd = seg_mem_reg[rd_idx];

    always_comb begin
        char_pat = font_lookup(chr_reg) & ~SEG_DP;
        if (!lit_reg) begin
            char_pat = ~char_pat & ~SEG_DP;
        end
        if (dot_reg == lit_reg) begin
            char_pat = char_pat | SEG_DP;
        end
    end

    assign rot_bits = seg_rotate(bits_reg, mirror_reg);
    assign rot_mask = seg_rotate(SEG_LSB << segi_reg, mirror_reg);

    // host actions
    always_comb begin
        seg_we      = 1'b0;
        seg_next    = seg_rd;
        per_we      = 1'b0;
        clr         = 1'b0;
        host_status = 1'b0;
        case (act_reg)
            ACT_PUT_CHAR: begin
                seg_we   = !bad;
                seg_next = seg_rotate(char_pat, mirror_reg);
            end
            ACT_PUT_SEGS: begin
                seg_we = !bad;
                if (merge_reg) begin
                    seg_next = lit_reg ? (seg_rd | rot_bits) : (seg_rd & ~rot_bits);
                end else begin
                    seg_next = seg_rotate(lit_reg ? bits_reg : ~bits_reg, mirror_reg);
                end
            end
            ACT_SET_SEG: begin
                seg_we   = !bad;
                seg_next = lit_reg ? (seg_rd | rot_mask) : (seg_rd & ~rot_mask);
            end
            ACT_SET_BLNK: begin
                per_we = !bad;
            end
            ACT_CLEAR: begin
                clr = 1'b1;
            end
            default: begin
            end
        endcase
        if (act_reg inside {ACT_PUT_CHAR, ACT_PUT_SEGS, ACT_SET_SEG, ACT_SET_BLNK}) begin
            host_status = bad;
        end
    end

    // blink timer of the digit under the index
    always_comb begin
        if (per_mem_reg[idx_reg] != '0) begin
            if (cnt_mem_reg[idx_reg] < per_mem_reg[idx_reg]) begin
                cnt_next = cnt_mem_reg[idx_reg] + PER_W'(1);
                ph_next  = ph_mem_reg[idx_reg];
            end else begin
                cnt_next = '0;
                ph_next  = !ph_mem_reg[idx_reg];
            end
        end else begin
            cnt_next = '0;
            ph_next  = 1'b0;
        end
    end

    assign out_load = cmd.exec_host || cmd.tick_step;

    always_comb begin
        if (cmd.tick_step) begin
            out_dreg_next   = REG_W'(idx_reg) + REG_W'(1);
            out_data_next   = ph_next ? SEG_BLANK : seg_rd;
            out_status_next = 1'b0;
            out_last_next   = sts.idx_last;
        end else begin
            out_dreg_next   = '0;
            out_data_next   = SEG_BLANK;
            out_status_next = host_status;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg    <= 1'b0;
            seg_mem_reg   <= '{default: '0};
            per_mem_reg   <= '{default: '0};
            cnt_mem_reg   <= '{default: '0};
            ph_mem_reg    <= '{default: '0};
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mirror_reg <= cfg_wr_data;
            end
            if (cmd.load_item) begin
                idx_reg <= '0;
            end
            if (cmd.tick_step) begin
                cnt_mem_reg[idx_reg] <= cnt_next;
                ph_mem_reg[idx_reg]  <= ph_next;
                if (!sts.idx_last) begin
                    idx_reg <= idx_reg + DIG_W'(1);
                end
            end
            if (cmd.exec_host) begin
                if (seg_we) begin
                    seg_mem_reg[dest] <= seg_next;
                end
                if (per_we) begin
                    per_mem_reg[dest] <= period_reg;
                end
                if (clr) begin
                    seg_mem_reg <= '{default: bits_reg};
                    per_mem_reg <= '{default: '0};
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg    <= s_action;
            pos_reg    <= s_position;
            chr_reg    <= s_char_code;
            bits_reg   <= s_segment_bits;
            segi_reg   <= s_segment_index;
            lit_reg    <= s_lit;
            dot_reg    <= s_with_dot;
            merge_reg  <= s_merge_only;
            period_reg <= s_blink_period;
        end
        if (out_load) begin
            out_dreg_reg   <= out_dreg_next;
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign sts.in_is_tick = (s_action == ACT_TICK);
    assign sts.out_free   = !out_valid_reg || m_ready;
    assign sts.idx_last   = (idx_reg == DIG_W'(DIGITS - 1));

    assign m_valid          = out_valid_reg;
    assign m_digit_register = out_dreg_reg;
    assign m_digit_data     = out_data_reg;
    assign m_status         = out_status_reg;
    assign m_last           = out_last_reg;

endmodule

### test/ssbd_display_checker.sv
`timescale 1ns / 100ps

module ssbd_display_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_position,
    input  logic [7:0]  s_char_code,
    input  logic [7:0]  s_segment_bits,
    input  logic [2:0]  s_segment_index,
    input  logic        s_lit,
    input  logic        s_with_dot,
    input  logic        s_merge_only,
    input  logic [15:0] s_blink_period,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [3:0]  m_digit_register,
    input  logic [7:0]  m_digit_data,
    input  logic        m_status,
    input  logic        m_last,
    output int          mismatches,
    output int          backlog
);
    import ssbd_pkg::*;

    typedef struct packed {
        logic [REG_W-1:0] reg_addr;
        logic [SEG_W-1:0] data;
        logic             status;
        logic             last;
    } result_t;

    result_t          pending_results[$];
    logic             mirror_on;
    logic [SEG_W-1:0] seg_mem    [DIGITS];
    logic [PER_W-1:0] period_mem [DIGITS];
    logic [PER_W-1:0] count_mem  [DIGITS];
    logic             phase_mem  [DIGITS];
    int               shown;

    // font, DP left clear
    function automatic logic [SEG_W-1:0] glyph_of(input logic [7:0] c);
        logic [SEG_W-1:0] g;
        case (c)
            "0": g = 8'h7E;
            "1": g = 8'h30;
            "2": g = 8'h6D;
            "3": g = 8'h79;
            "4": g = 8'h33;
            "5": g = 8'h5B;
            "6": g = 8'h5F;
            "7": g = 8'h70;
            "8": g = 8'h7F;
            "9": g = 8'h7B;
            "A", "a": g = 8'h77;
            "B", "b": g = 8'h1F;
            "C":      g = 8'h4E;
            "c":      g = 8'h0D;
            "D", "d": g = 8'h3D;
            "E", "e": g = 8'h4F;
            "F", "f": g = 8'h47;
            "G", "g": g = 8'h5E;
            "H":      g = 8'h37;
            "h":      g = 8'h17;
            "L", "l": g = 8'h0E;
            "O", "o": g = 8'h1D;
            "P", "p": g = 8'h67;
            "-": g = 8'h01;
            "_": g = 8'h08;
            "[": g = 8'h4E;
            "]": g = 8'h78;
            "{": g = 8'h31;
            "}": g = 8'h07;
            default: g = SEG_BLANK;
        endcase
        return g;
    endfunction

    // upside-down view: segment i moves three places, G and DP fixed
    function automatic logic [SEG_W-1:0] turned(input logic [SEG_W-1:0] v);
        logic [SEG_W-1:0] r;
        int dst;
        if (!mirror_on) return v;
        r = '0;
        for (int i = 0; i < SEG_W; i++) begin
            dst = (i == 0 || i == SEG_W - 1) ? i : ((i < 4) ? i + 3 : i - 3);
            r[dst] = v[i];
        end
        return r;
    endfunction

    task automatic predict_word();
        result_t res;
        logic [SEG_W-1:0] v;
        logic bad;
        int d;
        bad = (s_position >= DIGITS);
        d = mirror_on ? (DIGITS - 1 - int'(s_position)) : int'(s_position);
        if (s_action == ACT_TICK) begin
            for (int i = 0; i < DIGITS; i++) begin
                if (period_mem[i] == '0) begin
                    count_mem[i] = '0;
                    phase_mem[i] = 1'b0;
                end else if (count_mem[i] < period_mem[i]) begin
                    count_mem[i] = count_mem[i] + PER_W'(1);
                end else begin
                    count_mem[i] = '0;
                    phase_mem[i] = ~phase_mem[i];
                end
                res.reg_addr = REG_W'(i + 1);
                res.data     = phase_mem[i] ? SEG_BLANK : seg_mem[i];
                res.status   = 1'b0;
                res.last     = (i == DIGITS - 1);
                pending_results.push_back(res);
            end
        end else begin
            case (s_action)
                ACT_PUT_CHAR: if (!bad) begin
                    v = glyph_of(s_char_code) & 8'h7F;
                    if (!s_lit) v = ~v & 8'h7F;
                    if (s_with_dot == s_lit) v = v | SEG_DP;
                    seg_mem[d] = turned(v);
                end
                ACT_PUT_SEGS: if (!bad) begin
                    if (s_merge_only) begin
                        v = turned(s_segment_bits);
                        seg_mem[d] = s_lit ? (seg_mem[d] | v) : (seg_mem[d] & ~v);
                    end else begin
                        seg_mem[d] = turned(s_lit ? s_segment_bits : ~s_segment_bits);
                    end
                end
                ACT_SET_SEG: if (!bad) begin
                    v = turned(SEG_LSB << s_segment_index);
                    seg_mem[d] = s_lit ? (seg_mem[d] | v) : (seg_mem[d] & ~v);
                end
                ACT_SET_BLNK: if (!bad) begin
                    period_mem[d] = s_blink_period;
                end
                ACT_CLEAR: begin
                    // counters and phases wait for the next tick
                    for (int i = 0; i < DIGITS; i++) begin
                        seg_mem[i]    = s_segment_bits;
                        period_mem[i] = '0;
                    end
                end
                default: ;
            endcase
            res.reg_addr = '0;
            res.data     = SEG_BLANK;
            res.status   = bad && (s_action <= ACT_SET_BLNK);
            res.last     = 1'b1;
            pending_results.push_back(res);
        end
    endtask

    always @(posedge aclk) begin
        result_t seen, want;
        if (!aresetn) begin
            mirror_on = 1'b0;
            for (int i = 0; i < DIGITS; i++) begin
                seg_mem[i]    = '0;
                period_mem[i] = '0;
                count_mem[i]  = '0;
                phase_mem[i]  = 1'b0;
            end
            pending_results.delete();
            backlog <= 0;
        end else begin
            if (m_valid && m_ready) begin
                seen = '{m_digit_register, m_digit_data, m_status, m_last};
                if (pending_results.size() == 0) begin
                    if (shown < 10)
                        $display("%0t unexpected word: reg %0d data %02h status %0b last %0b",
                                 $realtime, seen.reg_addr, seen.data, seen.status, seen.last);
                    shown++;
                    mismatches <= mismatches + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (seen != want) begin
                        if (shown < 10)
                            $display({"%0t mismatch: expected reg %0d data %02h status %0b ",
                                      "last %0b, got reg %0d data %02h status %0b last %0b"},
                                     $realtime, want.reg_addr, want.data, want.status,
                                     want.last, seen.reg_addr, seen.data, seen.status,
                                     seen.last);
                        shown++;
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_word();
            if (cfg_wr_en) mirror_on = cfg_wr_data;
            backlog <= pending_results.size();
        end
    end

endmodule

### test/tb_seven_segment_blink_display_controller.sv
`timescale 1ns / 100ps

module tb_seven_segment_blink_display_controller;
    import ssbd_pkg::*;

    // action codes the block leaves undefined
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    localparam int LONG_HOLD_CYCLES = 300;              // receiver back-pressure burst
    localparam int SETTLE_CYCLES    = 4 * (DIGITS + 1) + 8;
    localparam int WORDS_PER_PHASE  = 80;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  position;
        logic [7:0]  char_code;
        logic [7:0]  segment_bits;
        logic [2:0]  segment_index;
        logic        lit;
        logic        with_dot;
        logic        merge_only;
        logic [15:0] blink_period;
    } host_word_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_wr_data     = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action        = '0;
    logic [3:0]  s_position      = '0;
    logic [7:0]  s_char_code     = '0;
    logic [7:0]  s_segment_bits  = '0;
    logic [2:0]  s_segment_index = '0;
    logic        s_lit           = 1'b0;
    logic        s_with_dot      = 1'b0;
    logic        s_merge_only    = 1'b0;
    logic [15:0] s_blink_period  = '0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [3:0]  m_digit_register;
    logic [7:0]  m_digit_data;
    logic        m_status;
    logic        m_last;

    int mismatches;
    int backlog;        // results still owed by the block

    // traffic shaping, percent of cycles
    int idle_pct  = 0;
    int stall_pct = 0;

    // long hold-off: stimulus flips the token, receiver counts the burst
    bit hold_token = 1'b0;
    bit hold_seen  = 1'b0;
    int hold_left  = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    seven_segment_blink_display_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_position      (s_position),
        .s_char_code     (s_char_code),
        .s_segment_bits  (s_segment_bits),
        .s_segment_index (s_segment_index),
        .s_lit           (s_lit),
        .s_with_dot      (s_with_dot),
        .s_merge_only    (s_merge_only),
        .s_blink_period  (s_blink_period),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digit_register(m_digit_register),
        .m_digit_data    (m_digit_data),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    ssbd_display_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_position      (s_position),
        .s_char_code     (s_char_code),
        .s_segment_bits  (s_segment_bits),
        .s_segment_index (s_segment_index),
        .s_lit           (s_lit),
        .s_with_dot      (s_with_dot),
        .s_merge_only    (s_merge_only),
        .s_blink_period  (s_blink_period),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digit_register(m_digit_register),
        .m_digit_data    (m_digit_data),
        .m_status        (m_status),
        .m_last          (m_last),
        .mismatches      (mismatches),
        .backlog         (backlog)
    );

    // Result side: random stalls, or a long solid hold when asked for.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one word; valid stays up (payload frozen) until the handshake.
    // Gaps are taken before raising valid, so valid never drops and rises
    // in the same step.
    task automatic send_word(input host_word_t w);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= w.action;
        s_position      <= w.position;
        s_char_code     <= w.char_code;
        s_segment_bits  <= w.segment_bits;
        s_segment_index <= w.segment_index;
        s_lit           <= w.lit;
        s_with_dot      <= w.with_dot;
        s_merge_only    <= w.merge_only;
        s_blink_period  <= w.blink_period;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait out every owed result plus the pipeline depth.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (backlog != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mirror_enable may only change while the block is idle
    task automatic write_mirror(input logic on);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic host_word_t make_word(input logic [2:0] act, input logic [3:0] pos,
                                             input logic [7:0] chr, input logic [7:0] bits,
                                             input logic [2:0] idx, input logic lit,
                                             input logic dot, input logic merge,
                                             input logic [15:0] period);
        host_word_t w;
        w = '{act, pos, chr, bits, idx, lit, dot, merge, period};
        return w;
    endfunction

    // Mostly legal, in-range traffic with ticks dominating, as in real use;
    // a few out-of-range positions and undefined actions mixed in.
    function automatic host_word_t random_word();
        host_word_t w;
        string glyphs;
        int pick;
        glyphs          = "0123456789AaBbCcDdEeFfGgHhLlOoPp-_[]{} ";
        w.char_code     = 8'($urandom);
        w.segment_bits  = 8'($urandom);
        w.segment_index = 3'($urandom);
        w.lit           = 1'($urandom);
        w.with_dot      = 1'($urandom);
        w.merge_only    = 1'($urandom);
        w.blink_period  = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)      w.action = ACT_TICK;
        else if (pick < 55) w.action = ACT_PUT_CHAR;
        else if (pick < 70) w.action = ACT_PUT_SEGS;
        else if (pick < 82) w.action = ACT_SET_SEG;
        else if (pick < 92) w.action = ACT_SET_BLNK;
        else if (pick < 96) w.action = ACT_CLEAR;
        else                w.action = $urandom_range(1) ? ACT_RSVD_6 : ACT_RSVD_7;
        if ($urandom_range(99) < 88) w.position = 4'($urandom_range(DIGITS - 1));
        else                         w.position = 4'($urandom_range(15, DIGITS));
        if ($urandom_range(99) < 70) w.char_code = glyphs[$urandom_range(glyphs.len() - 1)];
        // short periods so phases actually flip within the run
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: w.blink_period = 16'($urandom_range(3));
            6:                w.blink_period = '0;
            7:                w.blink_period = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tick on a dark display, font and polarity corners
        send_word(make_word(ACT_TICK,     4'd0,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_PUT_CHAR, 4'd0,  "8",   8'h00, 3'd0, 1'b1, 1'b1, 1'b0, 16'h0));
        send_word(make_word(ACT_PUT_CHAR, 4'd1,  "c",   8'hFF, 3'd7, 1'b0, 1'b0, 1'b1, 16'h0));
        send_word(make_word(ACT_PUT_CHAR, 4'd2,  8'hFF, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 16'h0));
        // raw segments: replace and merge, both polarities
        send_word(make_word(ACT_PUT_SEGS, 4'd3,  8'h00, 8'hA5, 3'd0, 1'b1, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_PUT_SEGS, 4'd2,  8'h00, 8'h0F, 3'd0, 1'b0, 1'b0, 1'b1, 16'h0));
        send_word(make_word(ACT_PUT_SEGS, 4'd1,  8'h00, 8'h81, 3'd0, 1'b1, 1'b0, 1'b1, 16'h0));
        send_word(make_word(ACT_SET_SEG,  4'd0,  8'h00, 8'h00, 3'd7, 1'b0, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_SET_SEG,  4'd3,  8'h00, 8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 16'h0));
        // fastest blink on digit 0, slowest on digit 1
        send_word(make_word(ACT_SET_BLNK, 4'd0,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h1));
        send_word(make_word(ACT_SET_BLNK, 4'd1,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0,
                            16'hFFFF));
        // out-of-range positions: error status, state untouched
        send_word(make_word(ACT_PUT_CHAR, 4'd15, "8",   8'h00, 3'd0, 1'b1, 1'b1, 1'b0, 16'h0));
        send_word(make_word(ACT_PUT_SEGS, 4'(DIGITS), 8'h00, 8'hFF, 3'd0, 1'b1, 1'b0, 1'b0,
                            16'h0));
        send_word(make_word(ACT_SET_SEG,  4'd15, 8'h00, 8'h00, 3'd3, 1'b1, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_SET_BLNK, 4'(DIGITS), 8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0,
                            16'h2));
        repeat (3)
            send_word(make_word(ACT_TICK, 4'd0, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));
        // undefined actions: ok status even at a bad position
        send_word(make_word(ACT_RSVD_6,   4'd15, 8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_RSVD_7,   4'd15, 8'hFF, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1,
                            16'hFFFF));
        // clear ignores position; blink phase lingers until the next tick
        send_word(make_word(ACT_CLEAR,    4'd15, 8'h00, 8'hFF, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_TICK,     4'd0,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));

        // Directed, mirrored: digit order reversed and segments turned
        write_mirror(1'b1);
        send_word(make_word(ACT_PUT_CHAR, 4'd0,  "1",   8'h00, 3'd0, 1'b1, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_PUT_SEGS, 4'd3,  8'h00, 8'h7E, 3'd0, 1'b1, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_SET_SEG,  4'd1,  8'h00, 8'h00, 3'd6, 1'b1, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_SET_BLNK, 4'd3,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h1));
        send_word(make_word(ACT_TICK,     4'd0,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));
        send_word(make_word(ACT_CLEAR,    4'd2,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0, 16'h0));

        // Random phases: free flow, idle sender, stalling receiver, light both.
        // Mirror alternates per phase; set rates before the config write so
        // they are in effect by the first word.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 54; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 54; end
                default: begin idle_pct <= 8; stall_pct <= 8; end
            endcase
            write_mirror(ph == 1 || ph == 3);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // sender pauses until the block has drained completely
                if (ph == 1 && n == WORDS_PER_PHASE / 2) settle();
                // receiver goes dark while words keep coming: input backs up
                if (ph == 2 && n == 10) hold_token <= ~hold_token;
                send_word(random_word());
            end
        end

        settle();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
